FILE: sv/lzw_ew_pkg.sv
// constants shared by the lzw escape width encoder
package lzw_ew_pkg;

    localparam int unsigned DICT_BASE   = 256;
    localparam int unsigned START_WIDTH = 9;
    localparam int unsigned WIDTH_BITS  = 5;
    localparam int unsigned HASH_SHIFT  = 11;
    localparam logic [31:0] HASH_MULT   = 32'd2654435761;

endpackage

FILE: sv/lzw_escape_width_encoder.sv
// lzw encoder with escape-widened code width, hashed dictionary and lsb-first byte packer
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------
//  in       | in_valid / in_ready   | data_byte, end_of_stream
//  out      | out_valid / out_ready | packed_byte, final_byte
//
// an item that only starts a stream is taken in the idle state; a dictionary hit passes through
// the hash, probe and check states, repeating probe and check for each extra probe on a hash
// collision. a miss adds an escape setup state for each escape and the code, a packer step per
// byte chunk of each, and the after state to restart the phrase. the dictionary memory has one
// read port, so probing walks it one slot at a time. after reset, and after the pad state that
// ends each stream, a clearing pass wipes all TABLE_DEPTH slots; in_ready stays low meanwhile.
// the packer stalls when a byte is complete and the output register is still full.
// TABLE_DEPTH must be a power of two.
module lzw_escape_width_encoder #(
    parameter int CODE_BITS   = 12,
    parameter int TABLE_DEPTH = 8192
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] packed_byte,
    output logic       final_byte
);
    import lzw_ew_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = CODE_BITS + 8;
    localparam int CB = CODE_BITS;

    typedef struct packed {
        logic          valid;
        logic [KW-1:0] key;
        logic [CB-1:0] code;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE, ST_CHECK, ST_ESC, ST_PACK, ST_AFTER, ST_PAD
    } state_t;

    entry_t dict_mem [TABLE_DEPTH];
    entry_t rd_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    entry_t        mem_wd;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [7:0] byte_reg, byte_next;
    logic last_reg, last_next;
    logic [KW-1:0] key_reg, key_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW:0] probe_cnt_reg, probe_cnt_next;
    logic [CB-1:0] cur_reg, cur_next;
    logic [WIDTH_BITS-1:0] width_reg, width_next;
    logic [CB:0] nfree_reg, nfree_next;
    logic [7:0] part_reg, part_next;
    logic [2:0] pcnt_reg, pcnt_next;
    logic started_reg, started_next;
    logic [CB-1:0] code_reg, code_next;
    logic [CB-1:0] val_reg, val_next;
    logic [WIDTH_BITS-1:0] cnt_reg, cnt_next;
    logic esc_reg, esc_next;
    logic fin_reg, fin_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic out_final_reg, out_final_next;

    logic [31:0] key_mix;
    logic [AW-1:0] hash_slot;
    logic [CB:0] pow_w;
    logic [CB-1:0] ones_w;
    logic [3:0] avail, take, fill;
    logic [7:0] merged;
    logic slot_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[mem_wa] <= mem_wd;
        end
        rd_q <= dict_mem[slot_reg];
    end

    always_comb
    begin
        key_mix   = 32'(key_reg) ^ (32'(key_reg) >> HASH_SHIFT);
        hash_slot = AW'(key_mix[AW-1:0] * HASH_MULT[AW-1:0]);
        pow_w     = (CB+1)'(1) << width_reg;
        ones_w    = pow_w[CB-1:0] - CB'(1);
        avail     = 4'd8 - {1'b0, pcnt_reg};
        take      = (cnt_reg < WIDTH_BITS'(avail)) ? cnt_reg[3:0] : avail;
        fill      = {1'b0, pcnt_reg} + take;
        merged    = part_reg | 8'({val_reg[7:0]} << pcnt_reg);
        slot_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        cur_next       = cur_reg;
        width_next     = width_reg;
        nfree_next     = nfree_reg;
        part_next      = part_reg;
        pcnt_next      = pcnt_reg;
        started_next   = started_reg;
        code_next      = code_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        esc_next       = esc_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_final_next = out_final_reg;
        mem_we         = 1'b0;
        mem_wa         = clr_reg;
        mem_wd         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = data_byte;
                    last_next = end_of_stream;
                    if (!started_reg)
                    begin
                        cur_next     = CB'(data_byte);
                        started_next = 1'b1;
                        if (end_of_stream)
                        begin
                            code_next  = CB'(data_byte);
                            fin_next   = 1'b1;
                            state_next = ST_ESC;
                        end
                    end
                    else
                    begin
                        key_next   = {cur_reg, data_byte};
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                slot_next      = hash_slot;
                probe_cnt_next = '0;
                state_next     = ST_PROBE;
            end
            ST_PROBE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (rd_q.valid && rd_q.key == key_reg)
                begin
                    // phrase extends, no code out
                    cur_next = rd_q.code;
                    if (last_reg)
                    begin
                        code_next  = rd_q.code;
                        fin_next   = 1'b1;
                        state_next = ST_ESC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (rd_q.valid && probe_cnt_reg != (AW+1)'(TABLE_DEPTH - 1))
                begin
                    slot_next      = slot_reg + AW'(1);
                    probe_cnt_next = probe_cnt_reg + (AW+1)'(1);
                    state_next     = ST_PROBE;
                end
                else
                begin
                    if (nfree_reg < (CB+1)'(1) << CB)
                    begin
                        // a full table drops the phrase but still uses up the code
                        mem_we       = !rd_q.valid;
                        mem_wa       = slot_reg;
                        mem_wd.valid = 1'b1;
                        mem_wd.key   = key_reg;
                        mem_wd.code  = nfree_reg[CB-1:0];
                        nfree_next   = nfree_reg + (CB+1)'(1);
                    end
                    code_next  = cur_reg;
                    fin_next   = 1'b0;
                    state_next = ST_ESC;
                end
            end
            ST_ESC:
            begin
                if (width_reg < WIDTH_BITS'(CODE_BITS) && code_reg >= ones_w)
                begin
                    val_next = ones_w;
                    esc_next = 1'b1;
                end
                else
                begin
                    val_next = code_reg;
                    esc_next = 1'b0;
                end
                cnt_next   = width_reg;
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                if (fill != 4'd8 || slot_free)
                begin
                    val_next = val_reg >> take;
                    cnt_next = cnt_reg - WIDTH_BITS'(take);
                    if (fill == 4'd8)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = merged;
                        out_final_next = fin_reg && !esc_reg && cnt_reg == WIDTH_BITS'(take);
                        part_next      = '0;
                        pcnt_next      = '0;
                    end
                    else
                    begin
                        part_next = merged;
                        pcnt_next = fill[2:0];
                    end
                    if (cnt_reg == WIDTH_BITS'(take))
                    begin
                        if (esc_reg)
                        begin
                            width_next = width_reg + WIDTH_BITS'(1);
                            state_next = ST_ESC;
                        end
                        else if (fin_reg)
                        begin
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            state_next = ST_AFTER;
                        end
                    end
                end
            end
            ST_AFTER:
            begin
                cur_next = CB'(byte_reg);
                if (last_reg)
                begin
                    code_next  = CB'(byte_reg);
                    fin_next   = 1'b1;
                    state_next = ST_ESC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (pcnt_reg == 3'd0 || slot_free)
                begin
                    if (pcnt_reg != 3'd0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = part_reg;
                        out_final_next = 1'b1;
                    end
                    cur_next     = '0;
                    width_next   = WIDTH_BITS'(START_WIDTH);
                    nfree_next   = (CB+1)'(DICT_BASE);
                    part_next    = '0;
                    pcnt_next    = '0;
                    started_next = 1'b0;
                    clr_next     = '0;
                    state_next   = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cur_reg       <= '0;
            width_reg     <= WIDTH_BITS'(START_WIDTH);
            nfree_reg     <= (CB+1)'(DICT_BASE);
            part_reg      <= '0;
            pcnt_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            width_reg     <= width_next;
            nfree_reg     <= nfree_next;
            part_reg      <= part_next;
            pcnt_reg      <= pcnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        key_reg       <= key_next;
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        code_reg      <= code_next;
        val_reg       <= val_next;
        cnt_reg       <= cnt_next;
        esc_reg       <= esc_next;
        fin_reg       <= fin_next;
        out_byte_reg  <= out_byte_next;
        out_final_reg <= out_final_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign packed_byte = out_byte_reg;
    assign final_byte  = out_final_reg;

endmodule

FILE: bench/lzw_escape_width_checker.sv
// predictor and scoreboard for the lzw escape width encoder
module lzw_escape_width_checker #(
    parameter int CODE_BITS   = 12,
    parameter int TABLE_DEPTH = 8192
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] packed_byte,
    input  logic       final_byte,
    output int         fails,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lzw_ew_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_item_t;

    bit                      dict_used [TABLE_DEPTH];
    logic [CODE_BITS+7:0]    dict_key  [TABLE_DEPTH];
    logic [CODE_BITS-1:0]    dict_code [TABLE_DEPTH];
    logic [CODE_BITS-1:0]    phrase;
    logic [WIDTH_BITS-1:0]   width;
    logic [CODE_BITS:0]      free_code;
    logic [7:0]              acc_byte;
    int unsigned             acc_bits;
    bit                      started;
    out_item_t               packed_q[$];
    out_item_t               step_q[$];

    task automatic restart_stream();
        for (int i = 0; i < TABLE_DEPTH; i++)
            dict_used[i] = 1'b0;
        phrase    = '0;
        width     = WIDTH_BITS'(START_WIDTH);
        free_code = (CODE_BITS+1)'(DICT_BASE);
        acc_byte  = '0;
        acc_bits  = 0;
        started   = 1'b0;
    endtask

    function automatic int unsigned slot_of(input logic [CODE_BITS+7:0] key);
        longint unsigned k;
        k = longint'(key);
        k = (k ^ (k >> HASH_SHIFT)) * longint'(HASH_MULT);
        return int'(k % longint'(TABLE_DEPTH));
    endfunction

    task automatic push_bits(input int unsigned value, input int unsigned nbits);
        for (int unsigned i = 0; i < nbits; i++) begin
            acc_byte[acc_bits] = value[i];
            acc_bits++;
            if (acc_bits == 8) begin
                step_q.insert(step_q.size(), out_item_t'{acc_byte, 1'b0});
                acc_byte = '0;
                acc_bits = 0;
            end
        end
    endtask

    // escape with all ones and widen while the code does not fit
    task automatic push_code(input int unsigned code);
        while (width < CODE_BITS && code >= (1 << width) - 1) begin
            push_bits((1 << width) - 1, width);
            width++;
        end
        push_bits(code, width);
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [CODE_BITS+7:0] key;
        int unsigned          slot;
        bit                   hit;
        bit                   room;
        step_q.delete();
        if (!started) begin
            phrase  = CODE_BITS'(b);
            started = 1'b1;
        end else begin
            key  = {phrase, b};
            slot = slot_of(key);
            hit  = 1'b0;
            room = 1'b0;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                if (!dict_used[slot]) begin
                    room = 1'b1;
                    break;
                end
                if (dict_key[slot] == key) begin
                    hit = 1'b1;
                    break;
                end
                slot = (slot + 1) % TABLE_DEPTH;
            end
            if (hit) begin
                phrase = dict_code[slot];
            end else begin
                push_code(phrase);
                if (free_code < (1 << CODE_BITS)) begin
                    if (room) begin
                        dict_used[slot] = 1'b1;
                        dict_key[slot]  = key;
                        dict_code[slot] = free_code[CODE_BITS-1:0];
                    end
                    free_code++;
                end
                phrase = CODE_BITS'(b);
            end
        end
        if (last) begin
            push_code(phrase);
            if (acc_bits != 0)
                step_q.insert(step_q.size(), out_item_t'{acc_byte, 1'b0});
            if (step_q.size() > 0)
                step_q[step_q.size()-1].last = 1'b1;
            restart_stream();
        end
        foreach (step_q[i])
            packed_q.insert(packed_q.size(), step_q[i]);
    endtask

    always @(posedge clk) begin
        out_item_t want;
        if (!rst_n) begin
            fails   = 0;
            pending = 0;
            restart_stream();
        end else begin
            if (in_valid && in_ready)
                encode_byte(data_byte, end_of_stream);
            if (out_valid && out_ready) begin
                if (packed_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected output: packed_byte %02h final_byte %0b",
                                 packed_byte, final_byte);
                end else begin
                    want = packed_q.pop_front();
                    if (want.data !== packed_byte || want.last !== final_byte) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: packed_byte exp %02h got %02h, final_byte exp %0b got %0b",
                                     want.data, packed_byte, want.last, final_byte);
                    end
                end
            end
            pending = packed_q.size();
        end
    end

endmodule

FILE: bench/tb_lzw_escape_width_encoder.sv
// stimulus, flow control and verdict for the lzw escape width encoder
module tb_lzw_escape_width_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BITS   = 12;
    localparam int TABLE_DEPTH = 8192;
    localparam int CYCLE_LIMIT = 1500000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] packed_byte;
    logic       final_byte;
    int         fails;
    int         pending;
    int         cycles = 0;
    int         burst_left;
    int         items_sent;
    bit         hold_request;
    logic [7:0] stream_q[$];

    lzw_escape_width_encoder #(.CODE_BITS(CODE_BITS), .TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .end_of_stream(end_of_stream),
        .out_valid(out_valid), .out_ready(out_ready),
        .packed_byte(packed_byte), .final_byte(final_byte)
    );

    lzw_escape_width_checker #(.CODE_BITS(CODE_BITS), .TABLE_DEPTH(TABLE_DEPTH)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .end_of_stream(end_of_stream),
        .out_valid(out_valid), .out_ready(out_ready),
        .packed_byte(packed_byte), .final_byte(final_byte),
        .fails(fails), .pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid      = 1'b1;
        data_byte     = b;
        end_of_stream = last;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        burst_left--;
        items_sent++;
        if (burst_left == 0)
            in_valid = 1'b0;
    endtask

    task automatic send_stream();
        foreach (stream_q[i])
            send_item(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    // receiver: random stretches of always-ready, coin flips or mostly stalled
    initial begin
        int mode;
        int stretch;
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(1, 40);
            repeat (stretch) begin
                @(negedge clk);
                if (hold_request && !held) begin
                    held      = 1'b1;
                    out_ready = 1'b0;
                    repeat (500) @(negedge clk);
                end
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = $urandom_range(0, 1);
                    default: out_ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin
        int len;
        int alpha;
        burst_left    = 0;
        items_sent    = 0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-byte streams at both extremes
        stream_q = '{8'h00};
        send_stream();
        stream_q = '{8'hff};
        send_stream();
        // repeated byte builds growing phrases
        stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_stream();
        stream_q = '{8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02};
        send_stream();
        stream_q = '{8'haa, 8'h55, 8'hff};
        send_stream();

        // long stream: fill past 511 codes, then replay to emit wide codes behind escapes
        hold_request = 1'b1;
        for (int i = 0; i < 270; i++)
            stream_q.insert(stream_q.size(), 8'($urandom_range(0, 255)));
        for (int i = 225; i < 265; i++)
            stream_q.insert(stream_q.size(), stream_q[i]);
        send_stream();

        while (items_sent < 360) begin
            len   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
            alpha = ($urandom_range(0, 1) == 0) ? 3 : 255;
            for (int i = 0; i < len; i++)
                stream_q.insert(stream_q.size(), 8'($urandom_range(0, alpha)));
            send_stream();
        end
        in_valid = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
